@@ hdl/lmb_pkg.sv @@
// Shared types and constants for the level meter ballistics block.
`default_nettype none
package lmb_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned TickW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PEAK_RELEASE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_RELEASE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_TICKS   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_THRESH  = 3'd4;

  // Levels are signed Q7.8 dB.
  localparam logic signed [LevelW-1:0] DB_FLOOR    = -16'sd15360;
  localparam logic signed [LevelW-1:0] DB_CEIL     = 16'sd1536;
  localparam logic signed [LevelW-1:0] DB_KNEE_LOW = -16'sd4608;

  localparam logic [WeightW-1:0] RST_PEAK_RELEASE = 16'd7864;
  localparam logic [WeightW-1:0] RST_HOLD_RELEASE = 16'd3277;
  localparam logic [TickW-1:0]   RST_HOLD_TICKS   = 8'd40;
  localparam logic [TickW-1:0]   RST_CLIP_TICKS   = 8'd60;
  localparam logic signed [LevelW-1:0] RST_CLIP_THRESH = 16'sd0;

  // Division by a segment constant is a multiply by ceil(2^26/k) and a shift.
  localparam int unsigned BarNumW = 20;
  localparam int unsigned RecipW = 23;
  localparam int unsigned DivShift = 26;
  localparam logic [RecipW-1:0] RECIP_15 = 23'd4473925;
  localparam logic [RecipW-1:0] RECIP_45 = 23'd1491309;
  localparam logic [RecipW-1:0] RECIP_21 = 23'd3195661;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic in_load;
    logic mul_en;
    logic mul_hold;
    logic peak_upd;
    logic hold_upd;
    logic bar_num;
    logic bar_div;
    logic out_load;
  } cmd_t;

endpackage
`default_nettype wire

@@ hdl/level_meter_ballistics_top.sv @@
// Top level of the level meter ballistics block.
//
// Peak meter with ballistic release, peak hold and clip indicator.
// The input channel (in_valid_i, in_stall_o, peak_level_i) takes one meter
// tick carrying a signed Q7.8 dB level. The output channel (out_valid_o,
// out_stall_i and the five result ports) gives one result item per tick.
// An item is taken while its valid is high and its stall is low.
// The sequencer steps each item through its states in turn: the shared
// blend multiplier is used twice, and the bar mapping needs numerator,
// reciprocal multiply and offset steps. The input stalls until the
// result of the current item is loaded into the output register.
// A finished result waits in the output register while the receiver
// stalls; a following item is accepted and processed meanwhile, but the
// block holds it in its last step until the waiting result is taken.
// Reset restores the configuration defaults, sets both levels to -60 dB
// and clears the hold and clip counters and the clip flag.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must write it only while the block is idle, which the block
// does not enforce itself; writes to unknown indexes are ignored.
`default_nettype none
module level_meter_ballistics_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [lmb_pkg::LevelW-1:0]     peak_level_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [lmb_pkg::LevelW-1:0]          smoothed_peak_o,
  output logic signed [lmb_pkg::LevelW-1:0]          held_peak_o,
  output logic                                       clip_led_o,
  output logic [15:0]                                peak_bar_o,
  output logic [15:0]                                hold_bar_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [lmb_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire logic [lmb_pkg::CfgDataW-1:0]          cfg_data_i
);

  lmb_pkg::cmd_t cmd;

  lmb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lmb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .peak_level_i    (peak_level_i),
    .smoothed_peak_o (smoothed_peak_o),
    .held_peak_o     (held_peak_o),
    .clip_led_o      (clip_led_o),
    .peak_bar_o      (peak_bar_o),
    .hold_bar_o      (hold_bar_o)
  );

endmodule
`default_nettype wire

@@ hdl/lmb_bar.sv @@
// Bar height mapper lane: segment numerator, reciprocal multiply and final offset.
`default_nettype none
module lmb_bar (
  input  wire logic                                clk_i,
  input  wire logic signed [lmb_pkg::LevelW-1:0]   level_i,
  input  wire logic                                num_en_i,
  input  wire logic                                div_en_i,
  output logic [15:0]                              bar_o
);

  typedef enum logic [2:0] {
    SEG_ZERO  = 3'd0,
    SEG_FULL  = 3'd1,
    SEG_UPPER = 3'd2,
    SEG_MID   = 3'd3,
    SEG_LOW   = 3'd4
  } seg_e;

  localparam int unsigned ProdW = lmb_pkg::BarNumW + lmb_pkg::RecipW;

  seg_e                          seg_d, seg_q, seg2_q;
  logic [lmb_pkg::BarNumW-1:0]   num_d, num_q;
  logic [ProdW-1:0]              prod_d, prod_q;
  logic [lmb_pkg::RecipW-1:0]    recip;
  logic signed [20:0]            lvl_x;
  logic signed [20:0]            n_upper, n_mid, n_low;
  logic [15:0]                   quot;

  assign lvl_x   = 21'(level_i);
  assign n_upper = 21'sd835591 + lvl_x * 21'sd96;
  assign n_mid   = (lvl_x + 21'sd4608) * 21'sd224 + 21'sd22;
  assign n_low   = (lvl_x + 21'sd15360) * 21'sd64 + 21'sd10;

  always_comb begin
    if (level_i <= lmb_pkg::DB_FLOOR) begin
      seg_d = SEG_ZERO;
      num_d = '0;
    end else if (level_i >= lmb_pkg::DB_CEIL) begin
      seg_d = SEG_FULL;
      num_d = '0;
    end else if (level_i >= 16'sd0) begin
      seg_d = SEG_UPPER;
      num_d = n_upper[lmb_pkg::BarNumW-1:0];
    end else if (level_i >= lmb_pkg::DB_KNEE_LOW) begin
      seg_d = SEG_MID;
      num_d = n_mid[lmb_pkg::BarNumW-1:0];
    end else begin
      seg_d = SEG_LOW;
      num_d = n_low[lmb_pkg::BarNumW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (num_en_i) begin
      seg_q <= seg_d;
      num_q <= num_d;
    end
  end

  always_comb begin
    case (seg_q)
      SEG_UPPER: recip = lmb_pkg::RECIP_15;
      SEG_MID:   recip = lmb_pkg::RECIP_45;
      SEG_LOW:   recip = lmb_pkg::RECIP_21;
      default:   recip = '0;
    endcase
  end

  assign prod_d = ProdW'(num_q) * ProdW'(recip);

  always_ff @(posedge clk_i) begin
    if (div_en_i) begin
      prod_q <= prod_d;
      seg2_q <= seg_q;
    end
  end

  assign quot = prod_q[lmb_pkg::DivShift+15:lmb_pkg::DivShift];

  always_comb begin
    case (seg2_q)
      SEG_ZERO: bar_o = 16'd0;
      SEG_FULL: bar_o = 16'hFFFF;
      SEG_MID:  bar_o = 16'd32768 + quot;
      default:  bar_o = quot;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/lmb_dp.sv @@
// Datapath: configuration registers, meter state, shared blend multiplier and result register.
`default_nettype none
module lmb_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lmb_pkg::cmd_t                         cmd_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [lmb_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire logic [lmb_pkg::CfgDataW-1:0]          cfg_data_i,
  input  wire logic signed [lmb_pkg::LevelW-1:0]     peak_level_i,
  output logic signed [lmb_pkg::LevelW-1:0]          smoothed_peak_o,
  output logic signed [lmb_pkg::LevelW-1:0]          held_peak_o,
  output logic                                       clip_led_o,
  output logic [15:0]                                peak_bar_o,
  output logic [15:0]                                hold_bar_o
);

  logic [lmb_pkg::WeightW-1:0]        peak_w_q, hold_w_q;
  logic [lmb_pkg::TickW-1:0]          hold_ticks_q, clip_ticks_q;
  logic signed [lmb_pkg::LevelW-1:0]  clip_thr_q;

  logic signed [lmb_pkg::LevelW-1:0]  lvl_q;
  logic signed [lmb_pkg::LevelW-1:0]  peak_q, hold_q;
  logic [lmb_pkg::TickW-1:0]          hold_cnt_q, clip_cnt_q;
  logic                               clip_flag_q;
  logic [lmb_pkg::TickW-1:0]          hold_dec, clip_dec;

  logic signed [16:0]                 diff;
  logic signed [16:0]                 wt;
  logic signed [33:0]                 prod_d, prod_q, biased;
  logic signed [lmb_pkg::LevelW-1:0]  rnd;
  logic [15:0]                        peak_bar, hold_bar;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_w_q     <= lmb_pkg::RST_PEAK_RELEASE;
      hold_w_q     <= lmb_pkg::RST_HOLD_RELEASE;
      hold_ticks_q <= lmb_pkg::RST_HOLD_TICKS;
      clip_ticks_q <= lmb_pkg::RST_CLIP_TICKS;
      clip_thr_q   <= lmb_pkg::RST_CLIP_THRESH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lmb_pkg::CFG_PEAK_RELEASE: peak_w_q <= cfg_data_i;
        lmb_pkg::CFG_HOLD_RELEASE: hold_w_q <= cfg_data_i;
        lmb_pkg::CFG_HOLD_TICKS:   hold_ticks_q <= cfg_data_i[lmb_pkg::TickW-1:0];
        lmb_pkg::CFG_CLIP_TICKS:   clip_ticks_q <= cfg_data_i[lmb_pkg::TickW-1:0];
        lmb_pkg::CFG_CLIP_THRESH:  clip_thr_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      lvl_q <= peak_level_i;
    end
  end

  // The blend a*(1-w) + b*w is formed as a + (b - a)*w, so one multiplier serves both levels.
  always_comb begin
    if (cmd_i.mul_hold) begin
      diff = 17'(peak_q) - 17'(hold_q);
      wt   = {1'b0, hold_w_q};
    end else begin
      diff = 17'(lvl_q) - 17'(peak_q);
      wt   = {1'b0, peak_w_q};
    end
  end

  assign prod_d = 34'(diff) * 34'(wt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign biased   = prod_q + 34'sd32768;
  assign rnd      = biased[31:16];
  assign hold_dec = (hold_cnt_q == '0) ? '0 : hold_cnt_q - 1'b1;
  assign clip_dec = (clip_cnt_q == '0) ? '0 : clip_cnt_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= lmb_pkg::DB_FLOOR;
      hold_q      <= lmb_pkg::DB_FLOOR;
      hold_cnt_q  <= '0;
      clip_cnt_q  <= '0;
      clip_flag_q <= 1'b0;
    end else begin
      if (cmd_i.peak_upd) begin
        if (lvl_q > peak_q) begin
          peak_q <= lvl_q;
        end else begin
          peak_q <= peak_q + rnd;
        end
        if (lvl_q >= clip_thr_q) begin
          clip_flag_q <= 1'b1;
          clip_cnt_q  <= clip_ticks_q;
        end else begin
          clip_cnt_q <= clip_dec;
          if (clip_dec == '0) begin
            clip_flag_q <= 1'b0;
          end
        end
      end
      if (cmd_i.hold_upd) begin
        if (lvl_q > hold_q) begin
          hold_q     <= lvl_q;
          hold_cnt_q <= hold_ticks_q;
        end else begin
          hold_cnt_q <= hold_dec;
          if (hold_dec == '0) begin
            hold_q <= hold_q + rnd;
          end
        end
      end
    end
  end

  lmb_bar u_peak_bar (
    .clk_i    (clk_i),
    .level_i  (peak_q),
    .num_en_i (cmd_i.bar_num),
    .div_en_i (cmd_i.bar_div),
    .bar_o    (peak_bar)
  );

  lmb_bar u_hold_bar (
    .clk_i    (clk_i),
    .level_i  (hold_q),
    .num_en_i (cmd_i.bar_num),
    .div_en_i (cmd_i.bar_div),
    .bar_o    (hold_bar)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      smoothed_peak_o <= peak_q;
      held_peak_o     <= hold_q;
      clip_led_o      <= clip_flag_q;
      peak_bar_o      <= peak_bar;
      hold_bar_o      <= hold_bar;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lmb_ctrl.sv @@
// Controller: sequences one item through the datapath and owns both handshakes.
`default_nettype none
module lmb_ctrl (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output lmb_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_PEAK_MUL = 8'b0000_0010,
    ST_PEAK_UPD = 8'b0000_0100,
    ST_HOLD_MUL = 8'b0000_1000,
    ST_HOLD_UPD = 8'b0001_0000,
    ST_BAR_NUM  = 8'b0010_0000,
    ST_BAR_DIV  = 8'b0100_0000,
    ST_BAR_FIN  = 8'b1000_0000
  } state_e;

  state_e state_d, state_q;
  logic   out_valid_d, out_valid_q;
  logic   out_free;

  // The result register is free when empty or being taken in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_PEAK_MUL;
        end
      end
      ST_PEAK_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_PEAK_UPD;
      end
      ST_PEAK_UPD: begin
        cmd_o.peak_upd = 1'b1;
        state_d        = ST_HOLD_MUL;
      end
      ST_HOLD_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_hold = 1'b1;
        state_d        = ST_HOLD_UPD;
      end
      ST_HOLD_UPD: begin
        cmd_o.mul_hold = 1'b1;
        cmd_o.hold_upd = 1'b1;
        state_d        = ST_BAR_NUM;
      end
      ST_BAR_NUM: begin
        cmd_o.bar_num = 1'b1;
        state_d       = ST_BAR_DIV;
      end
      ST_BAR_DIV: begin
        cmd_o.bar_div = 1'b1;
        state_d       = ST_BAR_FIN;
      end
      ST_BAR_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_PEAK_MUL)
    else $error("accepted item did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_BAR_FIN))
    else $error("result shown without finishing an item");
`endif

endmodule
`default_nettype wire

@@ sim/level_meter_ballistics_top_test.sv @@
// Self-checking testbench for the level meter ballistics top level.
module level_meter_ballistics_top_test;

  localparam int NumRegs = 5;
  localparam int SettleCycles = 10;
  localparam int QuietLimit = 2000;

  typedef struct {
    logic signed [lmb_pkg::LevelW-1:0] smoothed;
    logic signed [lmb_pkg::LevelW-1:0] held;
    logic                              clip;
    logic [15:0]                       peak_bar;
    logic [15:0]                       hold_bar;
  } meter_reading_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic signed [lmb_pkg::LevelW-1:0]   peak_level_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [lmb_pkg::LevelW-1:0]   smoothed_peak_o;
  logic signed [lmb_pkg::LevelW-1:0]   held_peak_o;
  logic                                clip_led_o;
  logic [15:0]                         peak_bar_o;
  logic [15:0]                         hold_bar_o;
  logic                                cfg_we_i = 1'b0;
  logic [lmb_pkg::CfgIdxW-1:0]         cfg_idx_i = '0;
  logic [lmb_pkg::CfgDataW-1:0]        cfg_data_i = '0;

  // Meter state as the block should hold it.
  logic signed [lmb_pkg::LevelW-1:0]   lvl_peak = lmb_pkg::DB_FLOOR;
  logic signed [lmb_pkg::LevelW-1:0]   lvl_hold = lmb_pkg::DB_FLOOR;
  logic [lmb_pkg::TickW-1:0]           hold_left = '0;
  logic [lmb_pkg::TickW-1:0]           clip_left = '0;
  logic                                clip_lit = 1'b0;

  // Register contents as the block should hold them.
  int unsigned                         rel_peak_w = lmb_pkg::RST_PEAK_RELEASE;
  int unsigned                         rel_hold_w = lmb_pkg::RST_HOLD_RELEASE;
  logic [lmb_pkg::TickW-1:0]           hold_span = lmb_pkg::RST_HOLD_TICKS;
  logic [lmb_pkg::TickW-1:0]           clip_span = lmb_pkg::RST_CLIP_TICKS;
  logic signed [lmb_pkg::LevelW-1:0]   clip_level = lmb_pkg::RST_CLIP_THRESH;

  meter_reading_t             pending_readings [$];
  int                         src_gap_max = 4;
  int                         sink_gap_max = 4;
  int                         sink_hold = 0;
  int                         wander = -3000;
  int                         quiet_cycles = 0;
  int                         n_sent = 0;
  int                         n_checked = 0;
  int                         n_writes = 0;
  int                         n_errors = 0;

  level_meter_ballistics_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .peak_level_i   (peak_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smoothed_peak_o(smoothed_peak_o),
    .held_peak_o    (held_peak_o),
    .clip_led_o     (clip_led_o),
    .peak_bar_o     (peak_bar_o),
    .hold_bar_o     (hold_bar_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // a*(1-w) + b*w in Q0.16 weights, rounded to nearest with halves going up.
  function automatic logic signed [lmb_pkg::LevelW-1:0] weigh_levels(
      input logic signed [lmb_pkg::LevelW-1:0] a,
      input logic signed [lmb_pkg::LevelW-1:0] b,
      input int unsigned w);
    longint acc;
    acc = longint'(a) * (longint'(65536) - longint'(w)) + longint'(b) * longint'(w)
          + longint'(32768);
    acc = acc >>> 16;
    return acc[lmb_pkg::LevelW-1:0];
  endfunction

  function automatic logic [15:0] level_to_bar(input logic signed [lmb_pkg::LevelW-1:0] d);
    int di;
    int h;
    di = d;
    if (di <= int'(lmb_pkg::DB_FLOOR)) h = 0;
    else if (di >= int'(lmb_pkg::DB_CEIL)) h = 65535;
    else if (di >= 0) h = (835584 + 96 * di + 7) / 15;
    else if (di >= int'(lmb_pkg::DB_KNEE_LOW))
      h = 32768 + (224 * (di - int'(lmb_pkg::DB_KNEE_LOW)) + 22) / 45;
    else h = (64 * (di - int'(lmb_pkg::DB_FLOOR)) + 10) / 21;
    return h[15:0];
  endfunction

  function automatic meter_reading_t meter_tick(input logic signed [lmb_pkg::LevelW-1:0] lvl);
    meter_reading_t r;
    if (lvl > lvl_peak) lvl_peak = lvl;
    else lvl_peak = weigh_levels(lvl_peak, lvl, rel_peak_w);

    if (lvl > lvl_hold) begin
      lvl_hold = lvl;
      hold_left = hold_span;
    end else begin
      if (hold_left != 0) hold_left = hold_left - 1'b1;
      if (hold_left == 0) lvl_hold = weigh_levels(lvl_hold, lvl_peak, rel_hold_w);
    end

    if (lvl >= clip_level) begin
      clip_lit = 1'b1;
      clip_left = clip_span;
    end else begin
      if (clip_left != 0) clip_left = clip_left - 1'b1;
      if (clip_left == 0) clip_lit = 1'b0;
    end

    r.smoothed = lvl_peak;
    r.held = lvl_hold;
    r.clip = clip_lit;
    r.peak_bar = level_to_bar(lvl_peak);
    r.hold_bar = level_to_bar(lvl_hold);
    return r;
  endfunction

  // Mostly a wandering, mostly falling level with jumps, so that holds expire and
  // recapture; the rest is noise over the whole range and points on the boundaries.
  function automatic logic signed [lmb_pkg::LevelW-1:0] next_level();
    logic signed [31:0] v;
    int base;
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: begin
        case ($urandom_range(0, 6))
          0: base = lmb_pkg::DB_FLOOR;
          1: base = lmb_pkg::DB_KNEE_LOW;
          2: base = 0;
          3: base = lmb_pkg::DB_CEIL;
          4: base = clip_level;
          5: base = lvl_peak;
          default: base = lvl_hold;
        endcase
        v = base + int'($urandom_range(0, 2)) - 1;
      end
      2: begin
        wander = int'($urandom_range(0, 19000)) - 16000;
        v = wander;
      end
      default: begin
        wander = wander + int'($urandom_range(0, 450)) - 300;
        if (wander < -20000) wander = -20000;
        if (wander > 3000) wander = 3000;
        v = wander;
      end
    endcase
    return v[lmb_pkg::LevelW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s at result %0d: got %0h, expected %0h", what, n_checked, got, want);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic write_reg(input logic [lmb_pkg::CfgIdxW-1:0] idx,
                           input logic [lmb_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lmb_pkg::CFG_PEAK_RELEASE: rel_peak_w = data;
      lmb_pkg::CFG_HOLD_RELEASE: rel_hold_w = data;
      lmb_pkg::CFG_HOLD_TICKS:   hold_span = data[lmb_pkg::TickW-1:0];
      lmb_pkg::CFG_CLIP_TICKS:   clip_span = data[lmb_pkg::TickW-1:0];
      lmb_pkg::CFG_CLIP_THRESH:  clip_level = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_config(input logic [15:0] pw, input logic [15:0] hw,
                            input logic [15:0] ht, input logic [15:0] ct,
                            input logic [15:0] thr);
    write_reg(lmb_pkg::CFG_PEAK_RELEASE, pw);
    write_reg(lmb_pkg::CFG_HOLD_RELEASE, hw);
    write_reg(lmb_pkg::CFG_HOLD_TICKS, ht);
    write_reg(lmb_pkg::CFG_CLIP_TICKS, ct);
    write_reg(lmb_pkg::CFG_CLIP_THRESH, thr);
  endtask

  // Presents one item after a random gap and waits until the block takes it.
  // The valid is left high so that a following item can go out back to back.
  task automatic send_level(input logic signed [lmb_pkg::LevelW-1:0] lvl);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    peak_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(meter_tick(lvl));
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_run(input int n, input bit pause_midway);
    for (int i = 0; i < n; i++) begin
      send_level(next_level());
      if (pause_midway && i == n / 2) drain_results();
    end
    drain_results();
  endtask

  task automatic randomise_config();
    logic [lmb_pkg::TickW-1:0] ht;
    logic [lmb_pkg::TickW-1:0] ct;
    int thr;
    ht = ($urandom_range(0, 3) == 0) ? (lmb_pkg::TickW)'($urandom_range(0, 255))
                                      : (lmb_pkg::TickW)'($urandom_range(0, 24));
    ct = ($urandom_range(0, 3) == 0) ? (lmb_pkg::TickW)'($urandom_range(0, 255))
                                      : (lmb_pkg::TickW)'($urandom_range(0, 24));
    if ($urandom_range(0, 4) == 0) thr = int'($urandom_range(0, 65535)) - 32768;
    else thr = int'($urandom_range(0, 7500)) - 6000;
    // The upper data bits of the tick registers are random and must be ignored.
    set_config(16'($urandom), 16'($urandom), {8'($urandom), ht}, {8'($urandom), ct},
               thr[15:0]);
  endtask

  // Field extremes and every segment boundary of the bar mapping, at reset settings.
  task automatic test_corner_levels();
    logic signed [lmb_pkg::LevelW-1:0] corner_levels [16];
    corner_levels = '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
                      16'sd1535, 16'sd1536, 16'sd1537, -16'sd4607, -16'sd4608, -16'sd4609,
                      -16'sd15359, -16'sd15360, -16'sd15361, -16'sd32768};
    foreach (corner_levels[i]) send_level(corner_levels[i]);
    drain_results();
  endtask

  // With zero hold and clip ticks both indicators let go on the very next quieter tick.
  task automatic test_zero_ticks();
    set_config(lmb_pkg::RST_PEAK_RELEASE, lmb_pkg::RST_HOLD_RELEASE, 16'd0, 16'd0,
               lmb_pkg::RST_CLIP_THRESH);
    send_level(16'sd256);
    send_level(16'sd256);
    send_level(-16'sd256);
    send_level(-16'sd512);
    send_level(16'sd0);
    send_level(-16'sd1);
    drain_results();
  endtask

  task automatic test_register_extremes();
    // Levels never fall, hold releases at once, every item clips.
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
    send_level(-16'sd32768);
    random_run(60, 1'b0);
    // Fastest release, longest hold and clip, clipping only at full scale.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_level(16'sd32767);
    random_run(60, 1'b0);
    // Writes past the last register must leave everything as it is.
    for (int i = NumRegs; i < 2 ** lmb_pkg::CfgIdxW; i++)
      write_reg((lmb_pkg::CfgIdxW)'(i), 16'($urandom));
    random_run(60, 1'b0);
    set_config(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
    random_run(60, 1'b0);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 6; k++) begin
      src_gap_max = (k % 3 == 1) ? 0 : 4;
      sink_gap_max = (k % 3 == 2) ? 0 : 4;
      randomise_config();
      random_run(100, 1'b1);
    end
    src_gap_max = 4;
    sink_gap_max = 4;
  endtask

  task automatic test_back_to_back();
    src_gap_max = 0;
    sink_gap_max = 0;
    randomise_config();
    random_run(100, 1'b0);
    src_gap_max = 4;
    sink_gap_max = 4;
  endtask

  // The receiver waits a drawn number of cycles once each result is offered.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sink_hold = $urandom_range(0, sink_gap_max);
    else if (out_valid_o && sink_hold > 0) sink_hold--;
    out_stall_i <= (sink_hold != 0);
  end

  always @(posedge clk_i) begin : check_results
    meter_reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result with no item outstanding", 32'd0, 32'd0);
      end else begin
        want = pending_readings.pop_front();
        check_field("smoothed_peak", smoothed_peak_o, want.smoothed);
        check_field("held_peak", held_peak_o, want.held);
        check_field("clip_led", clip_led_o, want.clip);
        check_field("peak_bar", peak_bar_o, want.peak_bar);
        check_field("hold_bar", hold_bar_o, want.hold_bar);
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("level_meter_ballistics_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_levels();
    test_zero_ticks();
    test_register_extremes();
    test_random_settings();
    test_back_to_back();
    drain_results();
    if (pending_readings.size() != 0)
      report_mismatch("results never delivered", pending_readings.size(), 32'd0);
    $display("covered %0d items and %0d results across %0d register writes,",
             n_sent, n_checked, n_writes);
    $display("including extreme weights, tick counts, thresholds and unused indexes");
    if (n_errors == 0) begin
      $display("level_meter_ballistics_top_test: done, clean");
    end else begin
      $display("level_meter_ballistics_top_test: done, errors");
    end
    $finish;
  end

endmodule
